// ===== rtl/lbptc_pkg.sv =====
// Package for the LED blink/PWM/timeout controller.
// Holds event codes, register indexes, reset values and the channel-to-bit map.
// No dependencies.
package lbptc_pkg;

    // channel counts
    localparam int NUM_CHANNELS = 7;
    localparam int NUM_BLINK    = 2;
    localparam int NUM_PWM      = NUM_CHANNELS - NUM_BLINK;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 3;
    localparam int DUTY_W   = 8;
    localparam int PCT_W    = 7;
    localparam int STEP_W   = 10;
    localparam int TIME_W   = 16;
    localparam int LED_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int PROD_W   = TIME_W + PCT_W;

    // duty clamp and percent scale
    localparam logic [PCT_W-1:0] DUTY_MAX = 7'd100;

    // event codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DUTY  = 2'd2
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP    = 3'd0,
        CFG_RUN_PERIOD   = 3'd1,
        CFG_RUN_TIMEOUT  = 3'd2,
        CFG_SEND_PERIOD  = 3'd3,
        CFG_SEND_TIMEOUT = 3'd4,
        CFG_LOAD_PERIOD  = 3'd5
    } t_cfg_idx;

    // register reset values
    localparam logic [STEP_W-1:0] RST_TICK_STEP    = 10'd10;
    localparam logic [TIME_W-1:0] RST_RUN_PERIOD   = 16'd500;
    localparam logic [TIME_W-1:0] RST_RUN_TIMEOUT  = 16'd500;
    localparam logic [TIME_W-1:0] RST_SEND_PERIOD  = 16'd200;
    localparam logic [TIME_W-1:0] RST_SEND_TIMEOUT = 16'd1000;
    localparam logic [TIME_W-1:0] RST_LOAD_PERIOD  = 16'd100;
    localparam logic [LED_W-1:0]  RST_LAST_SENT    = 8'hFF;

    // channel number that means "no channel"
    localparam logic [CHAN_W-1:0] CH_NONE = 3'd7;

    // LED bit driven by each logical channel
    typedef logic [2:0] t_bit_idx;
    localparam t_bit_idx CHAN_BIT [NUM_CHANNELS] = '{
        3'd2, 3'd4, 3'd0, 3'd1, 3'd3, 3'd5, 3'd6
    };

endpackage

// ===== rtl/led_blink_pwm_timeout_controller_unit.sv =====
// Top level of the LED blink/PWM/timeout controller.
// Depends on lbptc_pkg.
//
// Takes one event word per cycle (tick, channel enable write or duty write) and
// returns one result word per tick: the 8-bit LED pattern and a flag set when it
// differs from the last pattern sent. Each event is finished in the cycle it is
// accepted; its tick result is registered in the output stage, so the rate is
// one event per clock until the skid fills. A two-entry output stage (main
// register plus skid) lets events keep entering while a result waits. The PWM
// on-time compare uses a registered period*duty product per PWM channel that is
// kept in step with every duty and period write. Configuration writes are taken
// every cycle and should only be issued while no result is pending.
module led_blink_pwm_timeout_controller_unit
    import lbptc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [CHAN_W-1:0]    i_channel,
    input  logic                 i_enable,
    input  logic [DUTY_W-1:0]    i_duty_percent,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LED_W-1:0]     o_led_pattern,
    output logic                 o_send,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration registers
    logic [STEP_W-1:0] r_tick_step;
    logic [TIME_W-1:0] r_run_period;
    logic [TIME_W-1:0] r_run_timeout;
    logic [TIME_W-1:0] r_send_period;
    logic [TIME_W-1:0] r_send_timeout;
    logic [TIME_W-1:0] r_load_period;
    logic [TIME_W-1:0] n_load_period;

    // channel state
    logic [NUM_CHANNELS-1:0] r_en, n_en;
    logic [TIME_W-1:0]       r_left  [NUM_BLINK];
    logic [TIME_W-1:0]       n_left  [NUM_BLINK];
    logic [TIME_W-1:0]       r_phase [NUM_CHANNELS];
    logic [TIME_W-1:0]       n_phase [NUM_CHANNELS];
    logic [PCT_W-1:0]        r_duty  [NUM_PWM];
    logic [PCT_W-1:0]        n_duty  [NUM_PWM];
    logic [PROD_W-1:0]       r_prod  [NUM_PWM];
    logic [LED_W-1:0]        r_last_sent, n_last_sent;

    // output stage
    logic             r_out_valid, r_skid_valid;
    logic [LED_W-1:0] r_out_pattern, r_skid_pattern;
    logic             r_out_send, r_skid_send;

    logic             in_fire, out_fire, push;
    logic [LED_W-1:0] tick_pattern;
    logic             tick_send;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign push        = in_fire && (i_func == FUNC_TICK);

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_out_pattern;
    assign o_send        = r_out_send;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step    <= RST_TICK_STEP;
            r_run_period   <= RST_RUN_PERIOD;
            r_run_timeout  <= RST_RUN_TIMEOUT;
            r_send_period  <= RST_SEND_PERIOD;
            r_send_timeout <= RST_SEND_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_STEP:    r_tick_step    <= i_cfg_data[STEP_W-1:0];
                CFG_RUN_PERIOD:   r_run_period   <= i_cfg_data;
                CFG_RUN_TIMEOUT:  r_run_timeout  <= i_cfg_data;
                CFG_SEND_PERIOD:  r_send_period  <= i_cfg_data;
                CFG_SEND_TIMEOUT: r_send_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // PWM period next value; it also feeds the product shadow
    always_comb begin
        n_load_period = r_load_period;
        if (i_cfg_valid && (i_cfg_index == CFG_LOAD_PERIOD)) begin
            n_load_period = i_cfg_data;
        end
    end

    // event processing: write, duty and tick in one pass
    always_comb begin
        logic [PCT_W-1:0]  v_duty;
        logic [TIME_W:0]   v_sum;
        logic [TIME_W-1:0] v_cnt;
        logic [TIME_W-1:0] v_period;
        logic [TIME_W-1:0] v_tmo;
        logic [PROD_W:0]   v_thresh;
        logic              v_on;

        n_en         = r_en;
        n_left       = r_left;
        n_phase      = r_phase;
        n_duty       = r_duty;
        n_last_sent  = r_last_sent;
        tick_pattern = '0;
        tick_send    = 1'b0;
        v_duty       = '0;
        v_sum        = '0;
        v_cnt        = '0;
        v_period     = '0;
        v_tmo        = '0;
        v_thresh     = '0;
        v_on         = 1'b0;

        if (in_fire) begin
            unique case (i_func)
                FUNC_WRITE: begin
                    if (i_channel != CH_NONE) begin
                        n_en[i_channel] = i_enable;
                        if (i_channel < CHAN_W'(NUM_BLINK)) begin
                            v_tmo = i_channel[0] ? r_send_timeout : r_run_timeout;
                            n_left[i_channel[0]] = i_enable ? v_tmo : '0;
                        end
                    end
                end
                FUNC_DUTY: begin
                    if (i_channel != CH_NONE) begin
                        v_duty = (i_duty_percent > DUTY_W'(DUTY_MAX)) ?
                                 DUTY_MAX : i_duty_percent[PCT_W-1:0];
                        if (i_channel >= CHAN_W'(NUM_BLINK)) begin
                            n_duty[CHAN_W'(i_channel - CHAN_W'(NUM_BLINK))] = v_duty;
                        end
                        n_en[i_channel] = (v_duty != '0);
                    end
                end
                FUNC_TICK: begin
                    // count down armed timeouts of the blink channels
                    for (int c = 0; c < NUM_BLINK; c++) begin
                        v_tmo = (c == 0) ? r_run_timeout : r_send_timeout;
                        if (v_tmo != '0 && r_left[c] != '0) begin
                            if (r_left[c] > TIME_W'(r_tick_step)) begin
                                n_left[c] = r_left[c] - TIME_W'(r_tick_step);
                            end else begin
                                n_left[c] = '0;
                                n_en[c]   = 1'b0;
                            end
                        end
                    end
                    // advance counters of enabled channels, build the pattern
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (n_en[c]) begin
                            if (c == 0)      v_period = r_run_period;
                            else if (c == 1) v_period = r_send_period;
                            else             v_period = r_load_period;
                            v_sum = {1'b0, r_phase[c]} + (TIME_W+1)'(r_tick_step);
                            v_cnt = (v_sum >= {1'b0, v_period}) ? '0 : v_sum[TIME_W-1:0];
                            n_phase[c] = v_cnt;
                            if (c < NUM_BLINK) begin
                                v_on = v_cnt < (v_period >> 1);
                            end else begin
                                // cnt < floor(p*d/100)  <=>  p*d >= 100*(cnt+1)
                                v_thresh = ((PROD_W+1)'(v_cnt) + (PROD_W+1)'(1))
                                           * (PROD_W+1)'(DUTY_MAX);
                                v_on = {1'b0, r_prod[c-NUM_BLINK]} >= v_thresh;
                            end
                            tick_pattern[CHAN_BIT[c]] = v_on;
                        end
                    end
                    tick_send = (tick_pattern != r_last_sent);
                    if (tick_send) begin
                        n_last_sent = tick_pattern;
                    end
                end
                default: ;
            endcase
        end
    end

    // channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en          <= '0;
            r_last_sent   <= RST_LAST_SENT;
            r_load_period <= RST_LOAD_PERIOD;
            for (int c = 0; c < NUM_BLINK; c++) begin
                r_left[c] <= '0;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_phase[c] <= '0;
            end
            for (int p = 0; p < NUM_PWM; p++) begin
                r_duty[p] <= '0;
                r_prod[p] <= '0;
            end
        end else begin
            r_en          <= n_en;
            r_last_sent   <= n_last_sent;
            r_load_period <= n_load_period;
            r_left        <= n_left;
            r_phase       <= n_phase;
            r_duty        <= n_duty;
            // product shadow always equals period * duty of the PWM channel
            for (int p = 0; p < NUM_PWM; p++) begin
                r_prod[p] <= PROD_W'(n_load_period) * PROD_W'(n_duty[p]);
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                if (r_out_valid && !out_fire) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_pattern <= r_skid_pattern;
                r_out_send    <= r_skid_send;
            end
        end else if (push) begin
            if (r_out_valid && !out_fire) begin
                r_skid_pattern <= tick_pattern;
                r_skid_send    <= tick_send;
            end else begin
                r_out_pattern <= tick_pattern;
                r_out_send    <= tick_send;
            end
        end
    end

endmodule

// ===== rtl/lbptc_checker.sv =====
// Port-level checker for the LED blink/PWM/timeout controller, with its bind.
// Depends on lbptc_pkg and the top level led_blink_pwm_timeout_controller_unit.
module lbptc_checker
    import lbptc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [FUNC_W-1:0]    i_func,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [LED_W-1:0]     o_led_pattern,
    input logic                 o_send
);

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // no result right out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_led_pattern) && $stable(o_send)))
        else $error("stalled result changed");

    // bit 7 of the pattern is never driven
    a_bit7_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_led_pattern[LED_W-1])
        else $error("pattern bit 7 set");

    // a tick into an empty output gives a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && in_fire && i_func == FUNC_TICK) |=> o_out_valid)
        else $error("tick produced no result");

    // a non-tick event into an empty output gives no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && (!in_fire || i_func != FUNC_TICK)) |=> !o_out_valid)
        else $error("result without a tick");

endmodule

bind led_blink_pwm_timeout_controller_unit lbptc_checker u_lbptc_checker (.*);
